// File: rtl/tlr_pkg.sv
// tlr_pkg: shared types and constants for the thick line rasterizer
`timescale 1ns / 1ps
package tlr_pkg;

    localparam logic [12:0] MAX_DIM = 13'd4096;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] REG_IMG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_IMG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_LINE_THICKNESS = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } tlr_in_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        write_enable;
        logic        last;
    } tlr_out_t;

endpackage

// File: rtl/tlr_skid.sv
// tlr_skid: two-entry output buffer that decouples result stall from input stall
`timescale 1ns / 1ps
module tlr_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  tlr_pkg::tlr_out_t up_data,
    output logic              dn_valid,
    input  logic              dn_stall,
    output tlr_pkg::tlr_out_t dn_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    tlr_pkg::tlr_out_t main_reg;
    tlr_pkg::tlr_out_t main_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    tlr_pkg::tlr_out_t skid_reg;
    tlr_pkg::tlr_out_t skid_next;
    logic              push;
    logic              pop;

    assign up_stall = skid_valid_reg;
    assign dn_valid = main_valid_reg;
    assign dn_data  = main_reg;

    assign push = up_valid && !skid_valid_reg;
    assign pop  = main_valid_reg && !dn_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next       = up_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = up_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                // output is held, park the request in the skid slot
                skid_next       = up_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid slot full while main slot empty");

    a_skid_fills_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && dn_stall))
        else $error("skid slot filled while output was free");

    a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && dn_stall) |=> (main_valid_reg && main_reg == $past(main_reg)))
        else $error("held result changed");

endmodule

// File: rtl/thick_line_rasterizer.sv
// thick_line_rasterizer: bresenham line walk stamped with a disc brush
// a step request's result is registered in the output buffer and offered from its main slot
// throughput: one request per cycle, start or step, while the input is not stalled; a start request yields no result
// the walk state and disc compare sit between the state registers and the result register
// input stalls only while both result slots of the output buffer are occupied
// reset: line idle, config at 1024 x 1024 with thickness 1, output buffer empty
`timescale 1ns / 1ps
module thick_line_rasterizer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tlr_pkg::tlr_in_t  item,
    output logic              pix_valid,
    input  logic              pix_stall,
    output tlr_pkg::tlr_out_t pix,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [12:0]       cfg_data
);

    // configuration
    logic [12:0] img_width_reg;
    logic [12:0] img_height_reg;
    logic [5:0]  thickness_reg;

    // walk state
    logic               active_reg;
    logic               active_next;
    logic signed [16:0] cur_x_reg;
    logic signed [16:0] cur_x_next;
    logic signed [16:0] cur_y_reg;
    logic signed [16:0] cur_y_next;
    logic signed [15:0] target_x_reg;
    logic signed [15:0] target_x_next;
    logic signed [15:0] target_y_reg;
    logic signed [15:0] target_y_next;
    logic [16:0]        abs_dx_reg;
    logic [16:0]        abs_dx_next;
    logic signed [17:0] neg_abs_dy_reg;
    logic signed [17:0] neg_abs_dy_next;
    logic [1:0]         step_dirs_reg;
    logic [1:0]         step_dirs_next;
    logic signed [18:0] bres_err_reg;
    logic signed [18:0] bres_err_next;
    logic signed [6:0]  stamp_ox_reg;
    logic signed [6:0]  stamp_ox_next;
    logic signed [6:0]  stamp_oy_reg;
    logic signed [6:0]  stamp_oy_next;
    logic [23:0]        colour_reg;
    logic [23:0]        colour_next;

    logic accept;
    logic res_valid;
    tlr_pkg::tlr_out_t res;

    // start-time setup
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [16:0] ex;
    logic signed [16:0] ey;
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic [16:0]        mag_x;
    logic [16:0]        mag_y;

    // per-step evaluation
    logic [4:0]         radius;
    logic signed [6:0]  radius_s;
    logic [6:0]         mag_ox;
    logic [6:0]         mag_oy;
    logic [13:0]        sq_ox;
    logic [13:0]        sq_oy;
    logic [14:0]        sq_sum;
    logic [9:0]         sq_r;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [12:0]        w_clip;
    logic [12:0]        h_clip;
    logic               in_disc;
    logic               in_image;
    logic               row_end;
    logic               end_pt;
    logic               last;
    logic signed [19:0] e2;
    logic signed [19:0] err_sum;
    logic               step_x;
    logic               step_y;

    assign cfg_ready  = 1'b1;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= 13'd1024;
            img_height_reg <= 13'd1024;
            thickness_reg  <= 6'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tlr_pkg::REG_IMG_WIDTH:      img_width_reg  <= cfg_data;
                tlr_pkg::REG_IMG_HEIGHT:     img_height_reg <= cfg_data;
                tlr_pkg::REG_LINE_THICKNESS: thickness_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // start request setup
    always_comb
    begin
        sx     = 17'(item.start_x);
        sy     = 17'(item.start_y);
        ex     = 17'(item.end_x);
        ey     = 17'(item.end_y);
        diff_x = ex - sx;
        diff_y = ey - sy;
        mag_x  = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
        mag_y  = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
    end

    // disc test, clipping and end detection for the current candidate
    always_comb
    begin
        radius   = thickness_reg[5:1];
        radius_s = $signed({2'b00, radius});
        mag_ox   = stamp_ox_reg[6] ? 7'(-stamp_ox_reg) : 7'(stamp_ox_reg);
        mag_oy   = stamp_oy_reg[6] ? 7'(-stamp_oy_reg) : 7'(stamp_oy_reg);
        sq_ox    = 14'(mag_ox * mag_ox);
        sq_oy    = 14'(mag_oy * mag_oy);
        sq_sum   = {1'b0, sq_ox} + {1'b0, sq_oy};
        sq_r     = 10'(radius * radius);
        in_disc  = sq_sum <= {5'd0, sq_r};

        w_clip   = (img_width_reg  > tlr_pkg::MAX_DIM) ? tlr_pkg::MAX_DIM : img_width_reg;
        h_clip   = (img_height_reg > tlr_pkg::MAX_DIM) ? tlr_pkg::MAX_DIM : img_height_reg;
        px       = 18'(cur_x_reg) + 18'(stamp_ox_reg);
        py       = 18'(cur_y_reg) + 18'(stamp_oy_reg);
        in_image = !px[17] && (px[16:0] < {4'd0, w_clip})
                && !py[17] && (py[16:0] < {4'd0, h_clip});

        row_end  = stamp_ox_reg >= radius_s;
        end_pt   = (cur_x_reg == 17'(target_x_reg)) && (cur_y_reg == 17'(target_y_reg));
        last     = end_pt && row_end && (stamp_oy_reg >= radius_s);

        e2       = {bres_err_reg, 1'b0};
        step_x   = e2 >= 20'(neg_abs_dy_reg);
        step_y   = e2 <= $signed({3'b000, abs_dx_reg});
        err_sum  = 20'(bres_err_reg)
                 + (step_x ? 20'(neg_abs_dy_reg) : 20'sd0)
                 + (step_y ? $signed({3'b000, abs_dx_reg}) : 20'sd0);
    end

    // next state and result
    always_comb
    begin
        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        abs_dx_next     = abs_dx_reg;
        neg_abs_dy_next = neg_abs_dy_reg;
        step_dirs_next  = step_dirs_reg;
        bres_err_next   = bres_err_reg;
        stamp_ox_next   = stamp_ox_reg;
        stamp_oy_next   = stamp_oy_reg;
        colour_next     = colour_reg;

        res_valid = accept && (item.cmd == tlr_pkg::CMD_STEP);
        res       = '0;

        if (active_reg)
        begin
            if (in_disc && in_image)
            begin
                res.pixel_x      = px[11:0];
                res.pixel_y      = py[11:0];
                res.write_enable = 1'b1;
            end
            res.red_out   = colour_reg[23:16];
            res.green_out = colour_reg[15:8];
            res.blue_out  = colour_reg[7:0];
            res.last      = last;
        end
        else
        begin
            res.last = 1'b1;
        end

        if (accept)
        begin
            if (item.cmd == tlr_pkg::CMD_START)
            begin
                active_next     = 1'b1;
                cur_x_next      = sx;
                cur_y_next      = sy;
                target_x_next   = item.end_x;
                target_y_next   = item.end_y;
                abs_dx_next     = mag_x;
                neg_abs_dy_next = -$signed({1'b0, mag_y});
                step_dirs_next  = {!(sy < ey), !(sx < ex)};
                bres_err_next   = $signed({2'b00, mag_x}) - $signed({2'b00, mag_y});
                stamp_ox_next   = -radius_s;
                stamp_oy_next   = -radius_s;
                colour_next     = {item.red_in, item.green_in, item.blue_in};
            end
            else if (active_reg)
            begin
                if (last)
                begin
                    active_next = 1'b0;
                end
                else if (!row_end)
                begin
                    stamp_ox_next = stamp_ox_reg + 7'sd1;
                end
                else if (stamp_oy_reg < radius_s)
                begin
                    stamp_ox_next = -radius_s;
                    stamp_oy_next = stamp_oy_reg + 7'sd1;
                end
                else
                begin
                    // disc done at this point, advance the line
                    stamp_ox_next = -radius_s;
                    stamp_oy_next = -radius_s;
                    bres_err_next = err_sum[18:0];
                    if (step_x)
                    begin
                        cur_x_next = step_dirs_reg[0] ? cur_x_reg - 17'sd1 : cur_x_reg + 17'sd1;
                    end
                    if (step_y)
                    begin
                        cur_y_next = step_dirs_reg[1] ? cur_y_reg - 17'sd1 : cur_y_reg + 17'sd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            abs_dx_reg     <= '0;
            neg_abs_dy_reg <= '0;
            step_dirs_reg  <= '0;
            bres_err_reg   <= '0;
            stamp_ox_reg   <= '0;
            stamp_oy_reg   <= '0;
            colour_reg     <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            abs_dx_reg     <= abs_dx_next;
            neg_abs_dy_reg <= neg_abs_dy_next;
            step_dirs_reg  <= step_dirs_next;
            bres_err_reg   <= bres_err_next;
            stamp_ox_reg   <= stamp_ox_next;
            stamp_oy_reg   <= stamp_oy_next;
            colour_reg     <= colour_next;
        end
    end

    tlr_skid u_skid
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (res_valid),
        .up_stall (item_stall),
        .up_data  (res),
        .dn_valid (pix_valid),
        .dn_stall (pix_stall),
        .dn_data  (pix)
    );

    a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == tlr_pkg::CMD_START) |=> active_reg)
        else $error("start request did not activate the line");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == tlr_pkg::CMD_STEP && active_reg && last) |=> !active_reg)
        else $error("line still active after its final candidate");

    a_idle_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !active_reg) |-> (res.last && !res.write_enable))
        else $error("idle step result not marked last");

    a_no_write_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.write_enable) |-> (res.pixel_x == 12'd0 && res.pixel_y == 12'd0))
        else $error("clipped candidate carries coordinates");

endmodule
